// ===== rtl/ibmw_pkg.sv =====
// Shared request codes, walk level codes, field widths and types for the block map walker.
`default_nettype none

package ibmw_pkg;

    // Widths of the request and result fields.
    localparam int REQ_W  = 2;
    localparam int EIDX_W = 4;
    localparam int SBLK_W = 8;
    localparam int WIDX_W = 7;
    localparam int WORD_W = 32;
    localparam int LBLK_W = 22;

    typedef logic [REQ_W-1:0] req_t;
    typedef logic [1:0]       lvl_t;

    localparam req_t REQ_SET_ENTRY  = 2'd0;
    localparam req_t REQ_STORE_WORD = 2'd1;
    localparam req_t REQ_LOOKUP     = 2'd2;

    // Number of pointer-store reads still to do once the address entry is known.
    localparam lvl_t LVL_DIRECT = 2'd0;
    localparam lvl_t LVL_SINGLE = 2'd1;
    localparam lvl_t LVL_DOUBLE = 2'd2;
    localparam lvl_t LVL_TRIPLE = 2'd3;

    typedef struct packed {
        logic beyond;
        lvl_t level;
    } walk_start_t;

endpackage

`default_nettype wire

// ===== rtl/ibmw_level_dec.sv =====
// Splits a logical block number into its indirection level and the offset within that level.
`default_nettype none

module ibmw_level_dec
    import ibmw_pkg::*;
#(
    parameter int DIRECT_ENTRIES = 10,
    parameter int PTRS_PER_BLOCK = 128,
    localparam int REM_W = 3 * $clog2(PTRS_PER_BLOCK)
) (
    input  wire logic [LBLK_W-1:0] logical_block,
    output walk_start_t            start,
    output logic [REM_W-1:0]       rem
);

    localparam logic [31:0] SPAN0 = 32'(DIRECT_ENTRIES);
    localparam logic [31:0] SPAN1 = 32'(PTRS_PER_BLOCK);
    localparam logic [31:0] SPAN2 = 32'(PTRS_PER_BLOCK * PTRS_PER_BLOCK);
    localparam logic [31:0] SPAN3 = 32'(PTRS_PER_BLOCK * PTRS_PER_BLOCK * PTRS_PER_BLOCK);
    localparam logic [31:0] LIM1  = SPAN0;
    localparam logic [31:0] LIM2  = LIM1 + SPAN1;
    localparam logic [31:0] LIM3  = LIM2 + SPAN2;
    localparam logic [31:0] LIM4  = LIM3 + SPAN3;

    logic [31:0] lblk;
    logic [31:0] base;
    logic [31:0] diff;

    assign lblk = 32'(logical_block);

    // The level comparisons run in parallel against constant limits.
    always_comb begin
        start.beyond = 1'b0;
        if (lblk < LIM1) begin
            start.level = LVL_DIRECT;
            base        = 32'd0;
        end else if (lblk < LIM2) begin
            start.level = LVL_SINGLE;
            base        = LIM1;
        end else if (lblk < LIM3) begin
            start.level = LVL_DOUBLE;
            base        = LIM2;
        end else begin
            start.level  = LVL_TRIPLE;
            base         = LIM3;
            start.beyond = (lblk >= LIM4);
        end
    end

    assign diff = lblk - base;
    assign rem  = diff[REM_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/inode_block_map_walker.sv =====
// Block map walker: inode address table plus pointer store, lookups walk up to three levels.
//
// Input channel (s_valid/s_ready) carries one request word: set an address entry,
// write a pointer-store word, or look up a logical block. Writes give no result.
// A lookup gives one result word on the m_ channel with the
// physical block number and hole / store-miss flags.
// A lookup beyond the triple-indirect range ends at once as a hole, with no memory read.
// Other lookups walk a chain of dependent reads: one read of the address-entry
// memory, then one read of the pointer-store memory per level, each registered.
// While the output register is free, a new request is accepted in the cycle
// after the previous lookup finishes; writes go back to back.
// The result sits in an output register, so a new request is accepted while it
// waits. If the receiver still stalls when the next lookup finishes, that result
// is parked and the walker holds off further requests until the output frees.
// Reset (aresetn low, synchronous) clears the control state and the output valid.
// Memory contents are not cleared; entries must be written before they are read.
// PTRS_PER_BLOCK must be a power of two.
`default_nettype none

module inode_block_map_walker
    import ibmw_pkg::*;
#(
    parameter int DIRECT_ENTRIES = 10,
    parameter int PTRS_PER_BLOCK = 128,
    parameter int STORE_BLOCKS   = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [REQ_W-1:0]  s_req_type,
    input  wire logic [EIDX_W-1:0] s_entry_index,
    input  wire logic [SBLK_W-1:0] s_store_block,
    input  wire logic [WIDX_W-1:0] s_word_index,
    input  wire logic [WORD_W-1:0] s_value,
    input  wire logic [LBLK_W-1:0] s_logical_block,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [WORD_W-1:0]      m_physical_block,
    output logic                   m_is_hole,
    output logic                   m_store_miss
);

    localparam int NUM_ENTRIES = DIRECT_ENTRIES + 3;
    localparam int ENT_AW      = $clog2(NUM_ENTRIES);
    localparam int PB          = $clog2(PTRS_PER_BLOCK);
    localparam int SB_W        = $clog2(STORE_BLOCKS);
    localparam int PTR_AW      = SB_W + PB;
    localparam int STORE_WORDS = STORE_BLOCKS * PTRS_PER_BLOCK;
    localparam int REM_W       = 3 * PB;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ENTRY = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    lvl_t              lvl_reg, lvl_next;
    logic [REM_W-1:0]  rem_reg, rem_next;

    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_phys_reg, m_phys_next;
    logic              m_hole_reg, m_hole_next;
    logic              m_miss_reg, m_miss_next;

    logic [WORD_W-1:0] pend_phys_reg, pend_phys_next;
    logic              pend_hole_reg, pend_hole_next;
    logic              pend_miss_reg, pend_miss_next;

    logic [WORD_W-1:0] ent_mem [NUM_ENTRIES];
    logic [WORD_W-1:0] ent_rdata_reg;
    logic              ent_we, ent_re;
    logic [ENT_AW-1:0] ent_waddr, ent_raddr;

    logic [WORD_W-1:0] ptr_mem [STORE_WORDS];
    logic [WORD_W-1:0] ptr_rdata_reg;
    logic              ptr_we, ptr_re;
    logic [PTR_AW-1:0] ptr_waddr, ptr_raddr;

    walk_start_t       dec_start;
    logic [REM_W-1:0]  dec_rem;

    logic              accept;
    logic              out_free;
    logic              finish;
    logic [WORD_W-1:0] res_phys;
    logic              res_hole;
    logic              res_miss;
    logic [WORD_W-1:0] bn;
    logic [PB-1:0]     digit;

    ibmw_level_dec #(
        .DIRECT_ENTRIES (DIRECT_ENTRIES),
        .PTRS_PER_BLOCK (PTRS_PER_BLOCK)
    ) u_level_dec (
        .logical_block (s_logical_block),
        .start         (dec_start),
        .rem           (dec_rem)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_physical_block = m_phys_reg;
    assign m_is_hole        = m_hole_reg;
    assign m_store_miss     = m_miss_reg;

    // Pointer read data is only live after a walk step; the entry read feeds the first step.
    assign bn = (state_reg == ST_ENTRY) ? ent_rdata_reg : ptr_rdata_reg;

    always_comb begin
        case (lvl_reg)
            LVL_SINGLE: digit = rem_reg[PB-1:0];
            LVL_DOUBLE: digit = rem_reg[PB +: PB];
            LVL_TRIPLE: digit = rem_reg[2*PB +: PB];
            default:    digit = '0;
        endcase
    end

    assign ent_waddr = ENT_AW'(s_entry_index);
    assign ent_raddr = (dec_start.level == LVL_DIRECT) ? dec_rem[ENT_AW-1:0]
                     : ENT_AW'(DIRECT_ENTRIES + int'(dec_start.level) - 1);
    assign ptr_waddr = {SB_W'(s_store_block), PB'(s_word_index)};
    assign ptr_raddr = {bn[SB_W-1:0], digit};

    always_comb begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        rem_next   = rem_reg;
        ent_we     = 1'b0;
        ent_re     = 1'b0;
        ptr_we     = 1'b0;
        ptr_re     = 1'b0;
        finish     = 1'b0;
        res_phys   = '0;
        res_hole   = 1'b0;
        res_miss   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        REQ_SET_ENTRY: begin
                            ent_we = (32'(s_entry_index) < 32'(NUM_ENTRIES));
                        end
                        REQ_STORE_WORD: begin
                            ptr_we = (32'(s_store_block) < 32'(STORE_BLOCKS))
                                  && (32'(s_word_index) < 32'(PTRS_PER_BLOCK));
                        end
                        REQ_LOOKUP: begin
                            lvl_next = dec_start.level;
                            rem_next = dec_rem;
                            if (dec_start.beyond) begin
                                finish   = 1'b1;
                                res_hole = 1'b1;
                            end else begin
                                ent_re     = 1'b1;
                                state_next = ST_ENTRY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ENTRY, ST_WALK: begin
                if (bn == '0) begin
                    finish   = 1'b1;
                    res_hole = 1'b1;
                end else if (lvl_reg == LVL_DIRECT) begin
                    finish   = 1'b1;
                    res_phys = bn;
                end else if (bn >= 32'(STORE_BLOCKS)) begin
                    finish   = 1'b1;
                    res_miss = 1'b1;
                end else begin
                    ptr_re     = 1'b1;
                    lvl_next   = lvl_reg - 2'd1;
                    state_next = ST_WALK;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (finish) begin
            state_next = out_free ? ST_IDLE : ST_DONE;
        end
    end

    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_phys_next    = m_phys_reg;
        m_hole_next    = m_hole_reg;
        m_miss_next    = m_miss_reg;
        pend_phys_next = pend_phys_reg;
        pend_hole_next = pend_hole_reg;
        pend_miss_next = pend_miss_reg;
        if (finish) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_phys_next  = res_phys;
                m_hole_next  = res_hole;
                m_miss_next  = res_miss;
            end else begin
                pend_phys_next = res_phys;
                pend_hole_next = res_hole;
                pend_miss_next = res_miss;
            end
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_next = 1'b1;
            m_phys_next  = pend_phys_reg;
            m_hole_next  = pend_hole_reg;
            m_miss_next  = pend_miss_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg       <= lvl_next;
        rem_reg       <= rem_next;
        m_phys_reg    <= m_phys_next;
        m_hole_reg    <= m_hole_next;
        m_miss_reg    <= m_miss_next;
        pend_phys_reg <= pend_phys_next;
        pend_hole_reg <= pend_hole_next;
        pend_miss_reg <= pend_miss_next;
    end

    // Writes happen only in idle and reads only during a lookup, so no access overlaps.
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= s_value;
        end
        if (ent_re) begin
            ent_rdata_reg <= ent_mem[ent_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ptr_we) begin
            ptr_mem[ptr_waddr] <= s_value;
        end
        if (ptr_re) begin
            ptr_rdata_reg <= ptr_mem[ptr_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== tb/ibmw_map_checker.sv =====
// Result checker for the block map walker: tracks the tables, predicts each lookup and compares.
module ibmw_map_checker
    import ibmw_pkg::*;
#(
    parameter int DIRECT_ENTRIES = 10,
    parameter int PTRS_PER_BLOCK = 128,
    parameter int STORE_BLOCKS   = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [REQ_W-1:0]  s_req_type,
    input  wire logic [EIDX_W-1:0] s_entry_index,
    input  wire logic [SBLK_W-1:0] s_store_block,
    input  wire logic [WIDX_W-1:0] s_word_index,
    input  wire logic [WORD_W-1:0] s_value,
    input  wire logic [LBLK_W-1:0] s_logical_block,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [WORD_W-1:0] m_physical_block,
    input  wire logic              m_is_hole,
    input  wire logic              m_store_miss,
    output int                     map_errors,
    output int                     map_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ENTRIES = DIRECT_ENTRIES + 3;
    localparam int STORE_WORDS = STORE_BLOCKS * PTRS_PER_BLOCK;

    typedef struct packed {
        logic [WORD_W-1:0] physical_block;
        logic              is_hole;
        logic              store_miss;
    } map_result_t;

    logic [WORD_W-1:0] entry_table   [NUM_ENTRIES];
    logic [WORD_W-1:0] pointer_words [STORE_WORDS];
    map_result_t       expected_maps [$];
    int                lookups_checked = 0;

    // Walks the address table and the pointer store for one logical block.
    function automatic map_result_t map_block(input logic [LBLK_W-1:0] lblk);
        longint            span [4];
        longint            rem;
        longint            coeff;
        longint            pos;
        int                level;
        int                i;
        logic [WORD_W-1:0] bn;
        map_result_t       r;
        span[0] = DIRECT_ENTRIES;
        span[1] = PTRS_PER_BLOCK;
        span[2] = span[1] * PTRS_PER_BLOCK;
        span[3] = span[2] * PTRS_PER_BLOCK;
        r = '0;
        rem = lblk;
        level = -1;
        for (i = 0; i < 4; i++) begin
            if (level < 0) begin
                if (rem < span[i]) level = i;
                else rem -= span[i];
            end
        end
        if (level < 0) begin
            r.is_hole = 1'b1;
            return r;
        end
        bn = (level == 0) ? entry_table[rem] : entry_table[DIRECT_ENTRIES + level - 1];
        while (bn != 0 && level > 0) begin
            coeff = 1;
            for (i = 1; i < level; i++) coeff *= PTRS_PER_BLOCK;
            pos = rem / coeff;
            rem = rem % coeff;
            if (bn >= STORE_BLOCKS) begin
                r.store_miss = 1'b1;
                return r;
            end
            bn = pointer_words[longint'(bn) * PTRS_PER_BLOCK + pos];
            level--;
        end
        if (bn == 0) r.is_hole = 1'b1;
        else r.physical_block = bn;
        return r;
    endfunction

    always @(posedge aclk) begin
        map_result_t want;
        if (!aresetn) begin
            map_errors  = 0;
            map_pending = 0;
        end else begin
            // A result always belongs to an older lookup, so it is checked first.
            if (m_valid && m_ready) begin
                if (expected_maps.size() == 0) begin
                    map_errors++;
                    if (map_errors <= 10)
                        $display("ERROR: result word with no lookup pending: %h hole %b miss %b",
                                 m_physical_block, m_is_hole, m_store_miss);
                end else begin
                    want = expected_maps.pop_front();
                    if (want.physical_block !== m_physical_block ||
                        want.is_hole !== m_is_hole || want.store_miss !== m_store_miss) begin
                        map_errors++;
                        if (map_errors <= 10)
                            $display({"ERROR: lookup %0d: expected block %h hole %b miss %b, ",
                                      "got block %h hole %b miss %b"}, lookups_checked,
                                     want.physical_block, want.is_hole, want.store_miss,
                                     m_physical_block, m_is_hole, m_store_miss);
                    end
                    lookups_checked++;
                end
            end
            if (s_valid && s_ready) begin
                case (s_req_type)
                    REQ_SET_ENTRY: begin
                        if (s_entry_index < NUM_ENTRIES) entry_table[s_entry_index] = s_value;
                    end
                    REQ_STORE_WORD: begin
                        if (s_store_block < STORE_BLOCKS && s_word_index < PTRS_PER_BLOCK)
                            pointer_words[int'(s_store_block) * PTRS_PER_BLOCK
                                          + int'(s_word_index)] = s_value;
                    end
                    REQ_LOOKUP: begin
                        expected_maps.push_back(map_block(s_logical_block));
                    end
                    default: ;
                endcase
            end
            map_pending = expected_maps.size();
        end
    end

endmodule

// ===== tb/tb_inode_block_map_walker.sv =====
// Testbench top for the block map walker: clock, reset, request stimulus and the verdict.
module tb_inode_block_map_walker;
    timeunit 1ns;
    timeprecision 1ps;
    import ibmw_pkg::*;

    localparam int     DIRECT_ENTRIES = 10;
    localparam int     PTRS_PER_BLOCK = 128;
    localparam int     STORE_BLOCKS   = 256;
    localparam int     NUM_ENTRIES    = DIRECT_ENTRIES + 3;
    localparam int     STORE_WORDS    = STORE_BLOCKS * PTRS_PER_BLOCK;
    localparam int     FIRST_DOUBLE   = DIRECT_ENTRIES + PTRS_PER_BLOCK;
    localparam int     FIRST_TRIPLE   = FIRST_DOUBLE + PTRS_PER_BLOCK * PTRS_PER_BLOCK;
    localparam int     FIRST_BEYOND   = FIRST_TRIPLE
                                        + PTRS_PER_BLOCK * PTRS_PER_BLOCK * PTRS_PER_BLOCK;
    localparam int     TARGET_ITEMS   = 550;
    localparam longint CYCLE_LIMIT    = 1000000;
    localparam req_t   REQ_UNUSED     = 2'd3;

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [REQ_W-1:0]  s_req_type      = '0;
    logic [EIDX_W-1:0] s_entry_index   = '0;
    logic [SBLK_W-1:0] s_store_block   = '0;
    logic [WIDX_W-1:0] s_word_index    = '0;
    logic [WORD_W-1:0] s_value         = '0;
    logic [LBLK_W-1:0] s_logical_block = '0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [WORD_W-1:0] m_physical_block;
    logic              m_is_hole;
    logic              m_store_miss;
    int                map_errors;
    int                map_pending;

    // Shadow of what has been written, so that no lookup ever reads an unwritten location.
    logic [WORD_W-1:0] entry_shadow [NUM_ENTRIES];
    bit                entry_set    [NUM_ENTRIES];
    logic [WORD_W-1:0] store_shadow [STORE_WORDS];
    bit                store_set    [STORE_WORDS];
    int                recent_words  [$];
    logic [LBLK_W-1:0] recent_blocks [$];
    int                accepted_items = 0;
    bit                sender_calm    = 1'b0;
    bit                receiver_calm  = 1'b0;
    int                ready_hold     = 0;
    longint            cycle_count    = 0;

    always #5 aclk = ~aclk;

    inode_block_map_walker #(
        .DIRECT_ENTRIES (DIRECT_ENTRIES),
        .PTRS_PER_BLOCK (PTRS_PER_BLOCK),
        .STORE_BLOCKS   (STORE_BLOCKS)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_entry_index    (s_entry_index),
        .s_store_block    (s_store_block),
        .s_word_index     (s_word_index),
        .s_value          (s_value),
        .s_logical_block  (s_logical_block),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_physical_block (m_physical_block),
        .m_is_hole        (m_is_hole),
        .m_store_miss     (m_store_miss)
    );

    ibmw_map_checker #(
        .DIRECT_ENTRIES (DIRECT_ENTRIES),
        .PTRS_PER_BLOCK (PTRS_PER_BLOCK),
        .STORE_BLOCKS   (STORE_BLOCKS)
    ) u_map_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_entry_index    (s_entry_index),
        .s_store_block    (s_store_block),
        .s_word_index     (s_word_index),
        .s_value          (s_value),
        .s_logical_block  (s_logical_block),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_physical_block (m_physical_block),
        .m_is_hole        (m_is_hole),
        .m_store_miss     (m_store_miss),
        .map_errors       (map_errors),
        .map_pending      (map_pending)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Pointer values mostly lead deeper into the store; some end the walk as a hole or a miss.
    function automatic logic [WORD_W-1:0] pick_pointer();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 11) return 32'hFFFF_FFFF;
        if (r < 14) return $urandom_range(STORE_BLOCKS, STORE_BLOCKS + 300);
        return $urandom_range(1, STORE_BLOCKS - 1);
    endfunction

    function automatic logic [WORD_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 10) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [LBLK_W-1:0] pick_logical();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return LBLK_W'($urandom_range(0, DIRECT_ENTRIES - 1));
        if (r < 25) return LBLK_W'($urandom_range(DIRECT_ENTRIES, FIRST_DOUBLE - 1));
        if (r < 50) return LBLK_W'($urandom_range(FIRST_DOUBLE, FIRST_TRIPLE - 1));
        if (r < 88) return LBLK_W'($urandom_range(FIRST_TRIPLE, FIRST_BEYOND - 1));
        return LBLK_W'($urandom_range(FIRST_BEYOND, (1 << LBLK_W) - 1));
    endfunction

    // Receiver: random stalls of mixed length, with calm stretches where it starts no new stall.
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!receiver_calm && $urandom_range(0, 99) < 30) ready_hold <= pick_gap();
        end
        if ($urandom_range(0, 299) == 0) receiver_calm <= !receiver_calm;
    end

    task automatic send_word(input req_t rq, input logic [EIDX_W-1:0] eidx,
                             input logic [SBLK_W-1:0] sblk, input logic [WIDX_W-1:0] widx,
                             input logic [WORD_W-1:0] val, input logic [LBLK_W-1:0] lblk);
        int g;
        @(negedge aclk);
        s_req_type      <= rq;
        s_entry_index   <= eidx;
        s_store_block   <= sblk;
        s_word_index    <= widx;
        s_value         <= val;
        s_logical_block <= lblk;
        s_valid         <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!(rq == REQ_UNUSED || (rq == REQ_SET_ENTRY && eidx >= NUM_ENTRIES)))
            accepted_items++;
        g = 0;
        if (!sender_calm && $urandom_range(0, 99) < 35) g = pick_gap();
        if (g > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (g - 1) @(negedge aclk);
        end
    endtask

    task automatic set_entry(input logic [EIDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        send_word(REQ_SET_ENTRY, idx, SBLK_W'($urandom), WIDX_W'($urandom), val,
                  LBLK_W'($urandom));
        if (idx < NUM_ENTRIES) begin
            entry_shadow[idx] = val;
            entry_set[idx] = 1'b1;
        end
    endtask

    task automatic write_store(input logic [SBLK_W-1:0] blk, input logic [WIDX_W-1:0] widx,
                               input logic [WORD_W-1:0] val);
        int addr;
        addr = int'(blk) * PTRS_PER_BLOCK + int'(widx);
        send_word(REQ_STORE_WORD, EIDX_W'($urandom), blk, widx, val, LBLK_W'($urandom));
        store_shadow[addr] = val;
        store_set[addr] = 1'b1;
    endtask

    // Fills in every location on the walk that has not been written yet, then issues the lookup.
    task automatic lookup(input logic [LBLK_W-1:0] lblk);
        longint            span [4];
        longint            rem;
        longint            coeff;
        int                level;
        int                pos;
        int                i;
        int                eidx;
        int                addr;
        logic [WORD_W-1:0] bn;
        span[0] = DIRECT_ENTRIES;
        span[1] = PTRS_PER_BLOCK;
        span[2] = span[1] * PTRS_PER_BLOCK;
        span[3] = span[2] * PTRS_PER_BLOCK;
        rem = lblk;
        level = -1;
        for (i = 0; i < 4; i++) begin
            if (level < 0) begin
                if (rem < span[i]) level = i;
                else rem -= span[i];
            end
        end
        if (level >= 0) begin
            eidx = (level == 0) ? int'(rem) : DIRECT_ENTRIES + level - 1;
            if (!entry_set[eidx])
                set_entry(EIDX_W'(eidx), (level == 0) ? pick_data() : pick_pointer());
            bn = entry_shadow[eidx];
            while (bn != 0 && level > 0 && bn < STORE_BLOCKS) begin
                coeff = 1;
                for (i = 1; i < level; i++) coeff *= PTRS_PER_BLOCK;
                pos = int'(rem / coeff);
                rem = rem % coeff;
                addr = int'(bn) * PTRS_PER_BLOCK + pos;
                if (!store_set[addr])
                    write_store(bn[SBLK_W-1:0], pos[WIDX_W-1:0],
                                (level > 1) ? pick_pointer() : pick_data());
                recent_words.push_back(addr);
                if (recent_words.size() > 64) void'(recent_words.pop_front());
                bn = store_shadow[addr];
                level--;
            end
        end
        recent_blocks.push_back(lblk);
        if (recent_blocks.size() > 32) void'(recent_blocks.pop_front());
        send_word(REQ_LOOKUP, EIDX_W'($urandom), SBLK_W'($urandom), WIDX_W'($urandom),
                  $urandom, lblk);
    endtask

    initial begin
        int r;
        int addr;
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed part: table extremes, ignored requests, and each way a walk can end.
        set_entry('0, 32'hFFFF_FFFF);
        set_entry(EIDX_W'(DIRECT_ENTRIES - 1), 32'h0);
        set_entry(4'hF, 32'h1234_5678);
        set_entry(EIDX_W'(NUM_ENTRIES), 32'h0);
        send_word(REQ_UNUSED, '1, '1, '1, '1, '1);
        lookup('0);
        lookup(LBLK_W'(DIRECT_ENTRIES - 1));
        lookup('1);
        lookup(LBLK_W'(FIRST_BEYOND));
        set_entry(EIDX_W'(DIRECT_ENTRIES), 32'h0);
        lookup(LBLK_W'(DIRECT_ENTRIES));
        set_entry(EIDX_W'(DIRECT_ENTRIES), WORD_W'(STORE_BLOCKS));
        lookup(LBLK_W'(FIRST_DOUBLE - 1));
        set_entry(EIDX_W'(DIRECT_ENTRIES), WORD_W'(STORE_BLOCKS - 1));
        write_store('1, '1, 32'h1);
        lookup(LBLK_W'(FIRST_DOUBLE - 1));
        set_entry(EIDX_W'(DIRECT_ENTRIES), 32'hFFFF_FFFF);
        lookup(LBLK_W'(DIRECT_ENTRIES));
        set_entry(EIDX_W'(DIRECT_ENTRIES + 1), 32'h0);
        lookup(LBLK_W'(FIRST_DOUBLE));
        set_entry(EIDX_W'(DIRECT_ENTRIES + 2), 32'h0);
        lookup(LBLK_W'(FIRST_TRIPLE));
        set_entry(EIDX_W'(DIRECT_ENTRIES + 2), 32'h1);
        write_store('0, '0, 32'hFFFF_FFFF);
        lookup(LBLK_W'(FIRST_BEYOND - 1));

        // Random part: mostly lookups on prepared walks, mixed with overwrites and noise.
        while (accepted_items < TARGET_ITEMS) begin
            if ($urandom_range(0, 59) == 0) sender_calm = !sender_calm;
            r = $urandom_range(0, 99);
            if (r < 12 && recent_blocks.size() > 0) begin
                lookup(recent_blocks[$urandom_range(0, recent_blocks.size() - 1)]);
            end else if (r >= 12 && r < 26) begin
                if (recent_words.size() > 0 && $urandom_range(0, 1) == 1) begin
                    addr = recent_words[$urandom_range(0, recent_words.size() - 1)];
                    write_store(SBLK_W'(addr / PTRS_PER_BLOCK), WIDX_W'(addr % PTRS_PER_BLOCK),
                                $urandom_range(0, 1) ? pick_pointer() : pick_data());
                end else begin
                    write_store(SBLK_W'($urandom), WIDX_W'($urandom),
                                $urandom_range(0, 1) ? pick_pointer() : pick_data());
                end
            end else if (r >= 26 && r < 36) begin
                set_entry(EIDX_W'($urandom_range(0, 15)),
                          $urandom_range(0, 1) ? pick_pointer() : pick_data());
            end else if (r >= 36 && r < 40) begin
                send_word(REQ_UNUSED, EIDX_W'($urandom), SBLK_W'($urandom), WIDX_W'($urandom),
                          $urandom, LBLK_W'($urandom));
            end else begin
                lookup(pick_logical());
            end
        end

        @(negedge aclk) s_valid <= 1'b0;
        while (map_pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (map_errors == 0 && map_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ibmw_pkg.sv
rtl/ibmw_level_dec.sv
rtl/inode_block_map_walker.sv
tb/ibmw_map_checker.sv
tb/tb_inode_block_map_walker.sv
